[sv/assert_macros.svh]
// Assertion macros shared by the checker modules of the priority queue.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked at a later cycle than the antecedent.
`define SPQ_ASSERT_LATER(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("assertion failed");

`endif

[sv/spq_pkg.sv]
// Package for the stable priority queue: sizes, operation and status codes,
// and the command and status structures between controller and datapath.
// No dependencies.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int RANK_W   = 16;
	localparam int OCC_W    = 5;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic       load;
		logic       push;
		logic       pop;
		logic       finish;
		logic [1:0] code;
	} spq_ctrl_t;

	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
	} spq_sts_t;

endpackage

[sv/spq_ctrl.sv]
// Controller of the stable priority queue: sequences load, apply and reply.
// Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  spq_sts_t  sts,
	output spq_ctrl_t ctrl,
	output logic      busy,
	output logic      done
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_APPLY = 2'd1;
	localparam logic [1:0] S_REPLY = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		ctrl.code   = ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = S_APPLY;
				end
			end
			S_APPLY: begin
				ctrl.finish = 1'b1;
				if (sts.is_pop) begin
					if (sts.empty) begin
						ctrl.code = ST_EMPTY;
					end else begin
						ctrl.pop = 1'b1;
					end
				end else begin
					if (sts.full) begin
						ctrl.code = ST_FULL;
					end else begin
						ctrl.push = 1'b1;
					end
				end
				state_d = S_REPLY;
			end
			S_REPLY: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_REPLY);

endmodule

[sv/spq_dpath.sv]
// Datapath of the stable priority queue: a row of sorted slots, each with its
// own rank comparator, that shifts to insert or remove. Depends on spq_pkg.
module spq_dpath import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_ctrl_t                ctrl,
	output spq_sts_t                 sts,
	input  logic                     cmd,
	input  logic signed [VAL_W-1:0]  item_value,
	input  logic        [RANK_W-1:0] item_rank,
	output logic        [1:0]        status,
	output logic signed [VAL_W-1:0]  popped_value,
	output logic        [RANK_W-1:0] popped_rank,
	output logic                     front_valid,
	output logic signed [VAL_W-1:0]  front_value,
	output logic        [RANK_W-1:0] front_rank,
	output logic        [OCC_W-1:0]  occupancy
);

	logic        [VAL_W-1:0]  slot_val_q  [CAPACITY];
	logic        [RANK_W-1:0] slot_rank_q [CAPACITY];
	logic        [CNT_W-1:0]  count_q;
	logic                     cmd_q;
	logic        [VAL_W-1:0]  val_in_q;
	logic        [RANK_W-1:0] rank_in_q;
	logic        [1:0]        status_q;
	logic        [VAL_W-1:0]  pop_val_q;
	logic        [RANK_W-1:0] pop_rank_q;
	logic        [CAPACITY-1:0] after;

	// A slot lies after the insertion point when it is empty or holds a larger
	// rank. The list is sorted, so this flag is monotone along the row.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			after[i] = (CNT_W'(i) >= count_q) || (slot_rank_q[i] > rank_in_q);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		always_ff @(posedge clk) begin
			if (ctrl.push && after[i]) begin
				if (i == 0) begin
					slot_val_q[i]  <= val_in_q;
					slot_rank_q[i] <= rank_in_q;
				end else if (!after[(i == 0) ? 0 : i - 1]) begin
					slot_val_q[i]  <= val_in_q;
					slot_rank_q[i] <= rank_in_q;
				end else begin
					slot_val_q[i]  <= slot_val_q[(i == 0) ? 0 : i - 1];
					slot_rank_q[i] <= slot_rank_q[(i == 0) ? 0 : i - 1];
				end
			end else if (ctrl.pop && (i < CAPACITY - 1)) begin
				slot_val_q[i]  <= slot_val_q[(i < CAPACITY - 1) ? i + 1 : i];
				slot_rank_q[i] <= slot_rank_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q     <= cmd;
			val_in_q  <= item_value;
			rank_in_q <= item_rank;
		end
		if (ctrl.finish) begin
			status_q   <= ctrl.code;
			pop_val_q  <= ctrl.pop ? slot_val_q[0] : '0;
			pop_rank_q <= ctrl.pop ? slot_rank_q[0] : '0;
		end
	end

	assign sts.is_pop = (cmd_q == CMD_POP);
	assign sts.full   = (count_q == CNT_W'(CAPACITY));
	assign sts.empty  = (count_q == '0);

	assign status       = status_q;
	assign popped_value = pop_val_q;
	assign popped_rank  = pop_rank_q;
	assign front_valid  = (count_q != '0);
	assign front_value  = front_valid ? slot_val_q[0] : '0;
	assign front_rank   = front_valid ? slot_rank_q[0] : '0;
	assign occupancy    = OCC_W'(count_q);

endmodule

[sv/stable_priority_queue.sv]
// Top level of the stable priority queue: controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
//
// A bounded queue of 16 entries kept in ascending order of rank; a smaller
// rank is served first and equal ranks leave in arrival order.
// Commands: raise start with cmd, item_value and item_rank while busy is low;
// the transaction is taken at that clock edge. A push (cmd 0) inserts the
// entry, a pop (cmd 1) removes the head entry.
// Results: a command passes through the apply and reply states; done is high
// for exactly one cycle, in the reply state, and the result ports are valid
// in that cycle. status reports success, a pop on an empty queue or a push
// refused because the queue is full. The head entry and the count after the
// operation are shown too. A new command is taken only once the last is done;
// busy stays high from the edge that takes a command until the result cycle
// ends. A comparator on every slot decides shift, load or hold on insertion.
// The receiver cannot stall; results must be taken in their cycle.
// Reset empties the queue; slot contents are never read before written.
module stable_priority_queue import spq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cmd,
	input  logic signed [VAL_W-1:0]  item_value,
	input  logic        [RANK_W-1:0] item_rank,
	output logic                     done,
	output logic        [1:0]        status,
	output logic signed [VAL_W-1:0]  popped_value,
	output logic        [RANK_W-1:0] popped_rank,
	output logic                     front_valid,
	output logic signed [VAL_W-1:0]  front_value,
	output logic        [RANK_W-1:0] front_rank,
	output logic        [OCC_W-1:0]  occupancy
);

	spq_ctrl_t ctrl;
	spq_sts_t  sts;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctrl   (ctrl),
		.busy   (busy),
		.done   (done)
	);

	spq_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.sts          (sts),
		.cmd          (cmd),
		.item_value   (item_value),
		.item_rank    (item_rank),
		.status       (status),
		.popped_value (popped_value),
		.popped_rank  (popped_rank),
		.front_valid  (front_valid),
		.front_value  (front_value),
		.front_rank   (front_rank),
		.occupancy    (occupancy)
	);

endmodule

[sv/spq_checker.sv]
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_checker import spq_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [1:0]       status,
	input logic             front_valid,
	input logic [OCC_W-1:0] occupancy
);

	// Every accepted transaction gets its result, with done high.
	`SPQ_ASSERT_LATER(a_reply, start && !busy, done)
	// A result is only shown while the block still counts as busy.
	`SPQ_ASSERT_NOW(a_done_busy, done, busy)
	// A refused push can only happen on a full queue.
	`SPQ_ASSERT_NOW(a_full, done && (status == ST_FULL), occupancy == OCC_W'(CAPACITY))
	// The head flag agrees with the count.
	`SPQ_ASSERT_NOW(a_front, done, front_valid == (occupancy != '0))

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.front_valid (front_valid),
	.occupancy   (occupancy)
);

[verif/tb_stable_priority_queue.sv]
// Self-checking testbench for stable_priority_queue: push and pop transactions
// are checked against a shadow sorted list kept in the testbench.
// Depends on spq_pkg and the stable_priority_queue RTL.
module tb_stable_priority_queue import spq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int CALM_TAIL   = 40;

	typedef struct {
		logic                     opc;
		logic signed [VAL_W-1:0]  val;
		logic        [RANK_W-1:0] rnk;
		bit                       wait_drain;
		bit                       may_idle;
	} pq_op_t;

	typedef struct {
		logic        [1:0]        status;
		logic signed [VAL_W-1:0]  popped_value;
		logic        [RANK_W-1:0] popped_rank;
		logic                     front_valid;
		logic signed [VAL_W-1:0]  front_value;
		logic        [RANK_W-1:0] front_rank;
		logic        [OCC_W-1:0]  occupancy;
	} pq_reply_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     cmd = CMD_PUSH;
	logic signed [VAL_W-1:0]  item_value = '0;
	logic        [RANK_W-1:0] item_rank = '0;
	logic                     busy;
	logic                     done;
	logic        [1:0]        status;
	logic signed [VAL_W-1:0]  popped_value;
	logic        [RANK_W-1:0] popped_rank;
	logic                     front_valid;
	logic signed [VAL_W-1:0]  front_value;
	logic        [RANK_W-1:0] front_rank;
	logic        [OCC_W-1:0]  occupancy;

	pq_op_t    op_backlog[$];
	pq_reply_t expected_replies[$];

	// Shadow copy of the sorted list, head at index zero.
	logic signed [VAL_W-1:0]  shadow_value[CAPACITY];
	logic        [RANK_W-1:0] shadow_rank[CAPACITY];
	int                       shadow_fill = 0;

	int mismatches = 0;
	int cycle_count = 0;
	int gap_left = 0;

	stable_priority_queue u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.item_value   (item_value),
		.item_rank    (item_rank),
		.done         (done),
		.status       (status),
		.popped_value (popped_value),
		.popped_rank  (popped_rank),
		.front_valid  (front_valid),
		.front_value  (front_value),
		.front_rank   (front_rank),
		.occupancy    (occupancy)
	);

	always #5 clk = ~clk;

	function automatic pq_reply_t apply_to_shadow(logic opc, logic signed [VAL_W-1:0] v,
			logic [RANK_W-1:0] r);
		pq_reply_t rep;
		int        pos;
		rep.status       = ST_DONE;
		rep.popped_value = '0;
		rep.popped_rank  = '0;
		if (opc == CMD_PUSH) begin
			if (shadow_fill >= CAPACITY) begin
				rep.status = ST_FULL;
			end else begin
				// Insert ahead of the first strictly larger rank, so ties keep arrival order.
				pos = shadow_fill;
				for (int i = 0; i < shadow_fill; i++)
					if (pos == shadow_fill && shadow_rank[i] > r)
						pos = i;
				for (int i = shadow_fill; i > pos; i--) begin
					shadow_value[i] = shadow_value[i-1];
					shadow_rank[i]  = shadow_rank[i-1];
				end
				shadow_value[pos] = v;
				shadow_rank[pos]  = r;
				shadow_fill++;
			end
		end else begin
			if (shadow_fill == 0) begin
				rep.status = ST_EMPTY;
			end else begin
				rep.popped_value = shadow_value[0];
				rep.popped_rank  = shadow_rank[0];
				for (int i = 1; i < shadow_fill; i++) begin
					shadow_value[i-1] = shadow_value[i];
					shadow_rank[i-1]  = shadow_rank[i];
				end
				shadow_fill--;
			end
		end
		rep.front_valid = (shadow_fill > 0);
		rep.front_value = (shadow_fill > 0) ? shadow_value[0] : '0;
		rep.front_rank  = (shadow_fill > 0) ? shadow_rank[0] : '0;
		rep.occupancy   = OCC_W'(shadow_fill);
		return rep;
	endfunction

	function automatic bit field_differs(string name, logic [VAL_W-1:0] exp_v,
			logic [VAL_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic add_op(logic opc, logic signed [VAL_W-1:0] v, logic [RANK_W-1:0] r,
			bit hold, bit idle_ok);
		pq_op_t op;
		op.opc        = opc;
		op.val        = v;
		op.rnk        = r;
		op.wait_drain = hold;
		op.may_idle   = idle_ok;
		op_backlog.push_back(op);
	endtask

	// Bursts lean towards filling, draining, mixing or ties, so the queue
	// regularly reaches both full and empty.
	task automatic add_random_ops(int total);
		int made;
		int n;
		int mode;
		int push_pct;
		int rank_base;
		bit idle_ok;
		bit hold;
		logic [RANK_W-1:0] r;
		made = 0;
		while (made < total) begin
			n         = $urandom_range(8, 40);
			mode      = $urandom_range(0, 3);
			push_pct  = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			rank_base = $urandom_range(0, 16'hFFFC);
			idle_ok   = ($urandom_range(0, 9) < 7);
			hold      = ($urandom_range(0, 5) == 0);
			for (int k = 0; k < n; k++) begin
				case ($urandom_range(0, 9))
					0:       r = '0;
					1:       r = '1;
					2, 3, 4: r = RANK_W'(rank_base + $urandom_range(0, 3));
					default: r = RANK_W'($urandom);
				endcase
				if (mode == 3)
					r = RANK_W'(rank_base + $urandom_range(0, 2));
				add_op(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
					VAL_W'($urandom), r, hold && (k == 0),
					idle_ok && (total - made > CALM_TAIL));
				made++;
			end
		end
	endtask

	initial begin
		// Directed opening: empty pop, extreme values and ranks, ties at both ends.
		add_op(CMD_POP,  32'sh0000_0000, 16'h0000, 1'b0, 1'b1);
		add_op(CMD_PUSH, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0, 1'b1);
		add_op(CMD_PUSH, 32'sh8000_0000, 16'h0000, 1'b0, 1'b1);
		add_op(CMD_PUSH, 32'sh0000_0001, 16'h0000, 1'b0, 1'b1);
		add_op(CMD_PUSH, -32'sd1,        16'hFFFF, 1'b0, 1'b1);
		add_op(CMD_PUSH, 32'sh0000_0000, 16'h8000, 1'b0, 1'b1);
		for (int k = 0; k < 6; k++)
			add_op(CMD_POP, VAL_W'($urandom), RANK_W'($urandom), 1'b0, 1'b1);
		// Fill to capacity, overflow twice, then empty it again.
		for (int k = 0; k < 18; k++)
			add_op(CMD_PUSH, VAL_W'($urandom), RANK_W'($urandom_range(0, 5)), k == 0, 1'b0);
		for (int k = 0; k < 17; k++)
			add_op(CMD_POP, VAL_W'($urandom), RANK_W'($urandom), 1'b0, 1'b0);
		add_random_ops(460);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() != 0 || start || expected_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Driver: a transaction is taken at an edge where start is high and busy low.
	always @(posedge clk) begin
		logic nxt_start;
		nxt_start = start;
		if (arst_n) begin
			if (start && !busy) begin
				expected_replies.push_back(apply_to_shadow(cmd, item_value, item_rank));
				nxt_start = 1'b0;
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (op_backlog.size() != 0) begin
					if (op_backlog[0].wait_drain && expected_replies.size() != 0) begin
						// Hold off until every outstanding result has been seen.
					end else if (op_backlog[0].may_idle && $urandom_range(0, 7) == 0) begin
						gap_left = $urandom_range(1, 15) - 1;
					end else begin
						cmd        <= op_backlog[0].opc;
						item_value <= op_backlog[0].val;
						item_rank  <= op_backlog[0].rnk;
						void'(op_backlog.pop_front());
						nxt_start = 1'b1;
					end
				end
			end
		end
		start <= nxt_start;
	end

	// Monitor: a result is valid for the single cycle in which done is high.
	always @(posedge clk) begin
		pq_reply_t want;
		bit        bad;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$error("result transaction with no command outstanding");
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				bad  = field_differs("status", VAL_W'(want.status), VAL_W'(status));
				bad |= field_differs("popped_value", want.popped_value, popped_value);
				bad |= field_differs("popped_rank", VAL_W'(want.popped_rank),
					VAL_W'(popped_rank));
				bad |= field_differs("front_valid", VAL_W'(want.front_valid),
					VAL_W'(front_valid));
				bad |= field_differs("front_value", want.front_value, front_value);
				bad |= field_differs("front_rank", VAL_W'(want.front_rank),
					VAL_W'(front_rank));
				bad |= field_differs("occupancy", VAL_W'(want.occupancy), VAL_W'(occupancy));
				if (bad)
					mismatches++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

[sim.f]
+incdir+sv
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_dpath.sv
sv/stable_priority_queue.sv
sv/spq_checker.sv
verif/tb_stable_priority_queue.sv
